[rtl/core/bsa_pkg.sv]
// Shared types, constants and codes for the byte stack ALU.
`timescale 1ns / 1ps
package bsa_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int SP_AW       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QP_AW       = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] CMD_PUSH   = 4'd0;
  localparam logic [3:0] CMD_ADD    = 4'd1;
  localparam logic [3:0] CMD_SUB    = 4'd2;
  localparam logic [3:0] CMD_MUL    = 4'd3;
  localparam logic [3:0] CMD_DIV    = 4'd4;
  localparam logic [3:0] CMD_MOD    = 4'd5;
  localparam logic [3:0] CMD_DUP    = 4'd6;
  localparam logic [3:0] CMD_EQ     = 4'd7;
  localparam logic [3:0] CMD_LT     = 4'd8;
  localparam logic [3:0] CMD_GT     = 4'd9;
  localparam logic [3:0] CMD_NOT    = 4'd10;
  localparam logic [3:0] CMD_AND    = 4'd11;
  localparam logic [3:0] CMD_OR     = 4'd12;
  localparam logic [3:0] CMD_PUTCH  = 4'd13;
  localparam logic [3:0] CMD_PRINT  = 4'd14;
  localparam logic [3:0] CMD_PUTSTR = 4'd15;

  localparam logic [1:0] KIND_DONE = 2'd0;
  localparam logic [1:0] KIND_CHAR = 2'd1;
  localparam logic [1:0] KIND_NUM  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_UNDER = 2'd1;
  localparam logic [1:0] ERR_OVER  = 2'd2;
  localparam logic [1:0] ERR_DIV0  = 2'd3;

  localparam logic [7:0] REG_TRUE  = 8'd0;
  localparam logic [7:0] REG_FALSE = 8'd1;

  typedef enum logic [2:0] {
    CLS_PUSH,
    CLS_DUP,
    CLS_UNARY,
    CLS_BINARY,
    CLS_PUTSTR
  } bsa_cls_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UN,
    S_B,
    S_A,
    S_DIV,
    S_SCAN,
    S_EMIT,
    S_FIN
  } bsa_state_t;

  typedef struct packed {
    logic [3:0] command;
    logic [7:0] push_value;
  } bsa_in_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [1:0] error_code;
    logic [5:0] depth;
    logic       last;
  } bsa_out_t;

  typedef struct packed {
    bsa_cls_t   cls;
    logic [3:0] command;
    logic [7:0] push_value;
  } bsa_item_t;

  typedef struct packed {
    logic       we;
    logic [7:0] index;
    logic [7:0] wdata;
  } bsa_cfg_t;

endpackage

[rtl/core/bsa_front.sv]
// Front end: takes commands, classifies them and hands them to the queue.
`timescale 1ns / 1ps
module bsa_front
  import bsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  bsa_in_t   in_data,
  output logic      q_push,
  input  logic      q_ready,
  output bsa_item_t q_item
);

  logic      hold_valid_r, hold_valid_nxt;
  bsa_item_t hold_r, hold_nxt;
  logic      accept;

  assign in_stall = hold_valid_r && !q_ready;
  assign accept   = in_valid && !in_stall;
  assign q_push   = hold_valid_r && q_ready;
  assign q_item   = hold_r;

  always_comb begin
    hold_nxt            = hold_r;
    hold_nxt.command    = in_data.command;
    hold_nxt.push_value = in_data.push_value;
    case (in_data.command)
      CMD_PUSH:                       hold_nxt.cls = CLS_PUSH;
      CMD_DUP:                        hold_nxt.cls = CLS_DUP;
      CMD_NOT, CMD_PUTCH, CMD_PRINT:  hold_nxt.cls = CLS_UNARY;
      CMD_PUTSTR:                     hold_nxt.cls = CLS_PUTSTR;
      default:                        hold_nxt.cls = CLS_BINARY;
    endcase
    if (!accept) begin
      hold_nxt = hold_r;
    end
  end

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (q_push) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_r <= hold_nxt;
  end

endmodule

[rtl/core/bsa_fifo.sv]
// Short command queue between the front and back ends.
`timescale 1ns / 1ps
module bsa_fifo
  import bsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr_en,
  output logic      wr_ready,
  input  bsa_item_t wr_item,
  input  logic      rd_en,
  output logic      rd_valid,
  output bsa_item_t rd_item
);

  bsa_item_t         entries_r [QUEUE_DEPTH];
  logic [QP_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QP_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]   fill_r, fill_nxt;
  logic              do_wr, do_rd;

  assign wr_ready = fill_r != QC_W'(QUEUE_DEPTH);
  assign rd_valid = fill_r != '0;
  assign rd_item  = entries_r[rd_ptr_r];
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;

  always_comb begin
    wr_ptr_nxt = do_wr ? wr_ptr_r + QP_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = do_rd ? rd_ptr_r + QP_AW'(1) : rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + QC_W'(1);
    end else if (!do_wr && do_rd) begin
      fill_nxt = fill_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

[rtl/core/bsa_back.sv]
// Back end: stack memory, ALU, iterative divider, putstr walk and result register.
`timescale 1ns / 1ps
module bsa_back
  import bsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  bsa_cfg_t  cfg,
  input  logic      q_valid,
  input  bsa_item_t q_item,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output bsa_out_t  out_data
);

  // stack memory
  logic [7:0]       mem [STACK_DEPTH];
  logic             mem_we, mem_re;
  logic [SP_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;
  logic [7:0]       rd_data_r;

  bsa_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       true_r, false_r;

  bsa_cls_t         cls_r, cls_nxt;
  logic [3:0]       cmd_r, cmd_nxt;
  logic [7:0]       b_r, b_nxt;
  logic [7:0]       q_r, q_nxt;
  logic [7:0]       rem_r, rem_nxt;
  logic [2:0]       step_r, step_nxt;
  logic [SP_AW-1:0] idx_r, idx_nxt;
  logic [SP_AW-1:0] zero_r, zero_nxt;

  // pending final result and its stack update
  logic             fin_wr_r, fin_wr_nxt;
  logic [SP_AW-1:0] fin_waddr_r, fin_waddr_nxt;
  logic [7:0]       fin_wdata_r, fin_wdata_nxt;
  logic [CNT_W-1:0] fin_count_r, fin_count_nxt;
  logic [1:0]       fin_kind_r, fin_kind_nxt;
  logic [7:0]       fin_byte_r, fin_byte_nxt;
  logic [1:0]       fin_err_r, fin_err_nxt;

  logic             out_valid_r, out_valid_nxt;
  bsa_out_t         out_r, out_nxt;
  logic             out_free, out_load;

  logic [SP_AW-1:0] top_addr, below_addr;
  logic             empty, full, lt_two;
  logic [7:0]       opa;
  logic [15:0]      prod;
  logic [7:0]       alu_res;
  logic             is_divmod;
  logic [8:0]       div_shift;
  logic             div_ge;
  logic [7:0]       div_rem, div_quo;
  logic [CNT_W-1:0] cnt_dec;
  logic             last_char;

  assign out_free   = !out_valid_r || !out_stall;
  assign out_valid  = out_valid_r;
  assign out_data   = out_r;

  assign top_addr   = SP_AW'(count_r - CNT_W'(1));
  assign below_addr = SP_AW'(count_r - CNT_W'(2));
  assign empty      = count_r == '0;
  assign full       = count_r == CNT_W'(STACK_DEPTH);
  assign lt_two     = count_r < CNT_W'(2);
  assign cnt_dec    = count_r - CNT_W'(1);
  assign last_char  = cnt_dec == (CNT_W'(zero_r) + CNT_W'(1));

  assign opa        = rd_data_r;
  assign prod       = 16'(opa) * 16'(b_r);
  assign is_divmod  = (cmd_r == CMD_DIV) || (cmd_r == CMD_MOD);

  // one restoring step per cycle
  assign div_shift  = {rem_r, q_r[7]};
  assign div_ge     = div_shift >= {1'b0, b_r};
  assign div_rem    = div_ge ? 8'(div_shift - {1'b0, b_r}) : div_shift[7:0];
  assign div_quo    = {q_r[6:0], div_ge};

  always_comb begin
    case (cmd_r)
      CMD_ADD: alu_res = opa + b_r;
      CMD_SUB: alu_res = opa - b_r;
      CMD_MUL: alu_res = prod[7:0];
      CMD_EQ:  alu_res = (opa == b_r) ? true_r : false_r;
      CMD_LT:  alu_res = (opa < b_r) ? true_r : false_r;
      CMD_GT:  alu_res = (opa > b_r) ? true_r : false_r;
      CMD_AND: alu_res = (opa == true_r && b_r == true_r) ? true_r : false_r;
      default: alu_res = (opa == true_r || b_r == true_r) ? true_r : false_r;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          case (q_item.cls)
            CLS_DUP:    state_nxt = (empty || full) ? S_IDLE : S_UN;
            CLS_UNARY:  state_nxt = empty ? S_IDLE : S_UN;
            CLS_BINARY: state_nxt = lt_two ? S_IDLE : S_B;
            CLS_PUTSTR: state_nxt = empty ? S_IDLE : S_SCAN;
            default:    state_nxt = S_IDLE;
          endcase
        end
      end
      S_UN: state_nxt = S_FIN;
      S_B:  state_nxt = S_A;
      S_A:  state_nxt = (is_divmod && b_r != '0) ? S_DIV : S_FIN;
      S_DIV: begin
        if (step_r == 3'd7) begin
          state_nxt = S_FIN;
        end
      end
      S_SCAN: begin
        if (rd_data_r == '0) begin
          state_nxt = (idx_r == top_addr) ? S_FIN : S_EMIT;
        end else if (idx_r == '0) begin
          state_nxt = S_FIN;
        end
      end
      S_EMIT: begin
        if (out_free && last_char) begin
          state_nxt = S_IDLE;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = fin_waddr_r;
    mem_wdata     = fin_wdata_r;
    mem_re        = 1'b0;
    mem_raddr     = top_addr;
    out_load      = 1'b0;
    out_nxt       = out_r;
    count_nxt     = count_r;
    cls_nxt       = cls_r;
    cmd_nxt       = cmd_r;
    b_nxt         = b_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    idx_nxt       = idx_r;
    zero_nxt      = zero_r;
    fin_wr_nxt    = fin_wr_r;
    fin_waddr_nxt = fin_waddr_r;
    fin_wdata_nxt = fin_wdata_r;
    fin_count_nxt = fin_count_r;
    fin_kind_nxt  = fin_kind_r;
    fin_byte_nxt  = fin_byte_r;
    fin_err_nxt   = fin_err_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop              = 1'b1;
          cls_nxt            = q_item.cls;
          cmd_nxt            = q_item.command;
          out_nxt.kind       = KIND_DONE;
          out_nxt.data       = '0;
          out_nxt.error_code = ERR_NONE;
          out_nxt.depth      = 6'(count_r);
          out_nxt.last       = 1'b1;
          case (q_item.cls)
            CLS_PUSH: begin
              out_load = 1'b1;
              if (full) begin
                out_nxt.kind       = KIND_ERR;
                out_nxt.error_code = ERR_OVER;
              end else begin
                mem_we        = 1'b1;
                mem_waddr     = SP_AW'(count_r);
                mem_wdata     = q_item.push_value;
                count_nxt     = count_r + CNT_W'(1);
                out_nxt.depth = 6'(count_nxt);
              end
            end
            CLS_DUP, CLS_UNARY: begin
              if (empty) begin
                out_load           = 1'b1;
                out_nxt.kind       = KIND_ERR;
                out_nxt.error_code = ERR_UNDER;
              end else if (full && q_item.cls == CLS_DUP) begin
                out_load           = 1'b1;
                out_nxt.kind       = KIND_ERR;
                out_nxt.error_code = ERR_OVER;
              end else begin
                mem_re = 1'b1;
              end
            end
            CLS_BINARY: begin
              if (lt_two) begin
                out_load           = 1'b1;
                out_nxt.kind       = KIND_ERR;
                out_nxt.error_code = ERR_UNDER;
              end else begin
                mem_re = 1'b1;
              end
            end
            default: begin
              if (empty) begin
                out_load           = 1'b1;
                out_nxt.kind       = KIND_ERR;
                out_nxt.error_code = ERR_UNDER;
              end else begin
                mem_re  = 1'b1;
                idx_nxt = top_addr;
              end
            end
          endcase
        end
      end

      S_UN: begin
        fin_kind_nxt  = KIND_DONE;
        fin_byte_nxt  = '0;
        fin_err_nxt   = ERR_NONE;
        fin_wr_nxt    = 1'b1;
        fin_waddr_nxt = top_addr;
        fin_wdata_nxt = (rd_data_r == true_r) ? false_r : true_r;
        fin_count_nxt = count_r;
        if (cls_r == CLS_DUP) begin
          fin_waddr_nxt = SP_AW'(count_r);
          fin_wdata_nxt = rd_data_r;
          fin_count_nxt = count_r + CNT_W'(1);
        end else if (cmd_r == CMD_PUTCH || cmd_r == CMD_PRINT) begin
          fin_wr_nxt    = 1'b0;
          fin_count_nxt = cnt_dec;
          fin_kind_nxt  = (cmd_r == CMD_PUTCH) ? KIND_CHAR : KIND_NUM;
          fin_byte_nxt  = rd_data_r;
        end
      end

      S_B: begin
        b_nxt     = rd_data_r;
        mem_re    = 1'b1;
        mem_raddr = below_addr;
      end

      S_A: begin
        fin_kind_nxt  = KIND_DONE;
        fin_byte_nxt  = '0;
        fin_err_nxt   = ERR_NONE;
        fin_wr_nxt    = 1'b1;
        fin_waddr_nxt = below_addr;
        fin_wdata_nxt = alu_res;
        fin_count_nxt = cnt_dec;
        q_nxt         = opa;
        rem_nxt       = '0;
        step_nxt      = '0;
        if (is_divmod && b_r == '0) begin
          fin_wr_nxt    = 1'b0;
          fin_count_nxt = count_r;
          fin_kind_nxt  = KIND_ERR;
          fin_err_nxt   = ERR_DIV0;
        end
      end

      S_DIV: begin
        q_nxt    = div_quo;
        rem_nxt  = div_rem;
        step_nxt = step_r + 3'd1;
        fin_wdata_nxt = (cmd_r == CMD_DIV) ? div_quo : div_rem;
      end

      S_SCAN: begin
        fin_wr_nxt    = 1'b0;
        fin_count_nxt = count_r;
        fin_byte_nxt  = '0;
        if (rd_data_r == '0) begin
          fin_kind_nxt = KIND_DONE;
          fin_err_nxt  = ERR_NONE;
          zero_nxt     = idx_r;
          if (idx_r != top_addr) begin
            mem_re = 1'b1;
          end
        end else if (idx_r == '0) begin
          fin_kind_nxt = KIND_ERR;
          fin_err_nxt  = ERR_UNDER;
        end else begin
          idx_nxt   = idx_r - SP_AW'(1);
          mem_re    = 1'b1;
          mem_raddr = idx_r - SP_AW'(1);
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load           = 1'b1;
          out_nxt.kind       = KIND_CHAR;
          out_nxt.data       = rd_data_r;
          out_nxt.error_code = ERR_NONE;
          out_nxt.depth      = 6'(cnt_dec);
          out_nxt.last       = last_char;
          count_nxt          = cnt_dec;
          if (!last_char) begin
            mem_re    = 1'b1;
            mem_raddr = below_addr;
          end
        end
      end

      S_FIN: begin
        if (out_free) begin
          mem_we             = fin_wr_r;
          out_load           = 1'b1;
          out_nxt.kind       = fin_kind_r;
          out_nxt.data       = fin_byte_r;
          out_nxt.error_code = fin_err_r;
          out_nxt.depth      = 6'(fin_count_r);
          out_nxt.last       = 1'b1;
          count_nxt          = fin_count_r;
        end
      end

      default: begin
        q_pop = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      true_r      <= 8'd1;
      false_r     <= 8'd0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg.we && cfg.index == REG_TRUE) begin
        true_r <= cfg.wdata;
      end
      if (cfg.we && cfg.index == REG_FALSE) begin
        false_r <= cfg.wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    cls_r       <= cls_nxt;
    cmd_r       <= cmd_nxt;
    b_r         <= b_nxt;
    q_r         <= q_nxt;
    rem_r       <= rem_nxt;
    step_r      <= step_nxt;
    idx_r       <= idx_nxt;
    zero_r      <= zero_nxt;
    fin_wr_r    <= fin_wr_nxt;
    fin_waddr_r <= fin_waddr_nxt;
    fin_wdata_r <= fin_wdata_nxt;
    fin_count_r <= fin_count_nxt;
    fin_kind_r  <= fin_kind_nxt;
    fin_byte_r  <= fin_byte_nxt;
    fin_err_r   <= fin_err_nxt;
    out_r       <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

endmodule

[rtl/core/byte_stack_alu.sv]
// Top level of the byte stack ALU: front end, command queue and back end.
`timescale 1ns / 1ps
// Usage:
//   in_*  : one stack command per transfer (in_valid high, in_stall low).
//   out_* : result transfers; most commands give one result with last set,
//           putstr gives one character per byte popped, last on the final one.
//   cfg_* : register writes (index 0 true byte, index 1 false byte), taken
//           when cfg_valid and cfg_ready are high; other indexes are dropped.
// Timing: a command passes the front register and the queue; the back end
//   takes it when idle with its result register free. Back end steps:
//   push and errors found on the count are answered from idle; dup/not/
//   putch/print read the top, then close; binary operators read the top,
//   then the byte below, then close, div and mod after the divider (one
//   quotient bit per cycle); putstr scans down to the zero byte, emits each
//   character, or closes if none. Registered stack reads set these steps.
// Reset: synchronous, active low; empties the stack and queue and restores
//   true = 1, false = 0. Stack bytes are not cleared.
// Stall: a stalled result holds in the output register; the back end pauses
//   and the queue of four commands fills before in_stall is raised.
module byte_stack_alu
  import bsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  bsa_in_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output bsa_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_wdata
);

  logic      f_push, f_ready;
  bsa_item_t f_item;
  logic      b_pop, b_valid;
  bsa_item_t b_item;
  bsa_cfg_t  cfg;

  assign cfg_ready = 1'b1;
  assign cfg.we    = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  bsa_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (f_push),
    .q_ready  (f_ready),
    .q_item   (f_item)
  );

  bsa_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (f_push),
    .wr_ready (f_ready),
    .wr_item  (f_item),
    .rd_en    (b_pop),
    .rd_valid (b_valid),
    .rd_item  (b_item)
  );

  bsa_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (b_valid),
    .q_item    (b_item),
    .q_pop     (b_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // error results carry a code, no data, and close the command
  a_err_fields : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_ERR) |->
      (out_data.last && out_data.error_code != ERR_NONE && out_data.data == '0))
    else $error("error result malformed");

  a_ok_no_code : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind != KIND_ERR) |-> (out_data.error_code == ERR_NONE))
    else $error("error code on a non-error result");

  a_done_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_DONE) |-> (out_data.last && out_data.data == '0))
    else $error("done result not final");

endmodule

[test/bsa_checker.sv]
// Checker for the byte stack ALU: predicts every result and compares each output transfer.
`timescale 1ns / 1ps
module bsa_checker
  import bsa_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  bsa_in_t    in_data,
  input  logic       out_valid,
  input  logic       out_stall,
  input  bsa_out_t   out_data,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  output int         fail_count,
  output int         awaited_count,
  output int         predicted_depth,
  output int         result_count,
  output int         error_count
);

  logic [7:0] stack_bytes [STACK_DEPTH];
  int         stack_fill = 0;
  logic [7:0] true_byte  = 8'd1;
  logic [7:0] false_byte = 8'd0;
  bsa_out_t   awaited_results [$];
  int         mismatches    = 0;
  int         results_taken = 0;
  int         errors_taken  = 0;

  function automatic logic [7:0] flag_byte(input logic cond);
    return cond ? true_byte : false_byte;
  endfunction

  // depth is taken from the stack count at the moment the result is queued
  task automatic await_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic [1:0] code, input logic last);
    bsa_out_t r;
    r.kind       = kind;
    r.data       = data;
    r.error_code = code;
    r.depth      = stack_fill[5:0];
    r.last       = last;
    awaited_results = {awaited_results, r};
  endtask

  task automatic apply_stack_command(input bsa_in_t item);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    int         i;
    int         zero_pos;
    case (item.command)
      CMD_PUSH: begin
        if (stack_fill >= STACK_DEPTH) begin
          await_result(KIND_ERR, 8'd0, ERR_OVER, 1'b1);
        end else begin
          stack_bytes[stack_fill] = item.push_value;
          stack_fill++;
          await_result(KIND_DONE, 8'd0, ERR_NONE, 1'b1);
        end
      end
      CMD_DUP: begin
        if (stack_fill < 1) begin
          await_result(KIND_ERR, 8'd0, ERR_UNDER, 1'b1);
        end else if (stack_fill >= STACK_DEPTH) begin
          await_result(KIND_ERR, 8'd0, ERR_OVER, 1'b1);
        end else begin
          stack_bytes[stack_fill] = stack_bytes[stack_fill - 1];
          stack_fill++;
          await_result(KIND_DONE, 8'd0, ERR_NONE, 1'b1);
        end
      end
      CMD_NOT: begin
        if (stack_fill < 1) begin
          await_result(KIND_ERR, 8'd0, ERR_UNDER, 1'b1);
        end else begin
          stack_bytes[stack_fill - 1] = (stack_bytes[stack_fill - 1] == true_byte) ?
                                        false_byte : true_byte;
          await_result(KIND_DONE, 8'd0, ERR_NONE, 1'b1);
        end
      end
      CMD_PUTCH, CMD_PRINT: begin
        if (stack_fill < 1) begin
          await_result(KIND_ERR, 8'd0, ERR_UNDER, 1'b1);
        end else begin
          stack_fill--;
          await_result((item.command == CMD_PUTCH) ? KIND_CHAR : KIND_NUM,
                       stack_bytes[stack_fill], ERR_NONE, 1'b1);
        end
      end
      CMD_PUTSTR: begin
        // nearest zero byte from the top; it stays on the stack
        zero_pos = -1;
        i = stack_fill;
        while (i > 0 && zero_pos < 0) begin
          i--;
          if (stack_bytes[i] == 8'd0) zero_pos = i;
        end
        if (zero_pos < 0) begin
          await_result(KIND_ERR, 8'd0, ERR_UNDER, 1'b1);
        end else if (stack_fill == zero_pos + 1) begin
          await_result(KIND_DONE, 8'd0, ERR_NONE, 1'b1);
        end else begin
          while (stack_fill > zero_pos + 1) begin
            stack_fill--;
            await_result(KIND_CHAR, stack_bytes[stack_fill], ERR_NONE,
                         stack_fill == zero_pos + 1);
          end
        end
      end
      default: begin
        if (stack_fill < 2) begin
          await_result(KIND_ERR, 8'd0, ERR_UNDER, 1'b1);
        end else begin
          b = stack_bytes[stack_fill - 1];
          a = stack_bytes[stack_fill - 2];
          if ((item.command == CMD_DIV || item.command == CMD_MOD) && b == 8'd0) begin
            await_result(KIND_ERR, 8'd0, ERR_DIV0, 1'b1);
          end else begin
            case (item.command)
              CMD_ADD: r = a + b;
              CMD_SUB: r = a - b;
              CMD_MUL: r = a * b;
              CMD_DIV: r = a / b;
              CMD_MOD: r = a % b;
              CMD_EQ:  r = flag_byte(a == b);
              CMD_LT:  r = flag_byte(a < b);
              CMD_GT:  r = flag_byte(a > b);
              CMD_AND: r = flag_byte(a == true_byte && b == true_byte);
              default: r = flag_byte(a == true_byte || b == true_byte);
            endcase
            stack_fill -= 2;
            stack_bytes[stack_fill] = r;
            stack_fill++;
            await_result(KIND_DONE, 8'd0, ERR_NONE, 1'b1);
          end
        end
      end
    endcase
  endtask

  task automatic check_result(input bsa_out_t got);
    bsa_out_t want;
    results_taken++;
    if (got.kind == KIND_ERR) errors_taken++;
    if (awaited_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $write("%0t: result with none awaited: kind %0d data %02h err %0d",
               $realtime, got.kind, got.data, got.error_code);
        $display(" depth %0d last %0d", got.depth, got.last);
      end
    end else begin
      want = awaited_results.pop_front();
      if (got.kind !== want.kind || got.data !== want.data ||
          got.error_code !== want.error_code || got.depth !== want.depth ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $write("%0t: mismatch: want kind %0d data %02h err %0d depth %0d last %0d,",
                 $realtime, want.kind, want.data, want.error_code, want.depth,
                 want.last);
          $display(" got kind %0d data %02h err %0d depth %0d last %0d",
                   got.kind, got.data, got.error_code, got.depth, got.last);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_results.delete();
      stack_fill = 0;
      true_byte  = 8'd1;
      false_byte = 8'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_TRUE) true_byte = cfg_wdata;
        else if (cfg_index == REG_FALSE) false_byte = cfg_wdata;
      end
      if (in_valid && !in_stall) apply_stack_command(in_data);
      if (out_valid && !out_stall) check_result(out_data);
    end
    fail_count      <= mismatches;
    awaited_count   <= awaited_results.size();
    predicted_depth <= stack_fill;
    result_count    <= results_taken;
    error_count     <= errors_taken;
  end

endmodule

[test/byte_stack_alu_tb.sv]
// Testbench top for the byte stack ALU: clock, reset, command and flag stimulus, verdict.
`timescale 1ns / 1ps
module byte_stack_alu_tb;
  import bsa_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 46;
  localparam int OPENING      = 28;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  bsa_in_t    in_data   = '0;
  logic       out_stall = 1'b0;
  logic       cfg_valid = 1'b0;
  logic [7:0] cfg_index = 8'd0;
  logic [7:0] cfg_wdata = 8'd0;
  logic       in_stall;
  logic       out_valid;
  bsa_out_t   out_data;
  logic       cfg_ready;

  int fail_count;
  int awaited_count;
  int predicted_depth;
  int result_count;
  int error_count;

  int         idle_pct      = 0;
  int         stall_pct     = 0;
  int         sent_count    = 0;
  int         hold_requests = 0;
  int         holds_served  = 0;
  int         cycle_count   = 0;
  logic [7:0] cur_true      = 8'd1;
  logic [7:0] cur_false     = 8'd0;

  always #4 clk = ~clk;

  byte_stack_alu dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bsa_checker results_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .awaited_count   (awaited_count),
    .predicted_depth (predicted_depth),
    .result_count    (result_count),
    .error_count     (error_count)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // output side: random stall, or a long hold-off when one is requested
  initial begin
    forever begin
      @(posedge clk);
      if (hold_requests != holds_served) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        holds_served <= holds_served + 1;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // valid stays high from one transfer into the next unless a gap is drawn
  task automatic send_cmd(input logic [3:0] cmd, input logic [7:0] value);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= {cmd, value};
    do @(posedge clk); while (in_stall);
    sent_count++;
  endtask

  task automatic wait_drained(input int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (awaited_count != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic program_flags(input logic [7:0] t, input logic [7:0] f);
    logic [7:0] idx [3];
    logic [7:0] val [3];
    idx[0] = 8'($urandom_range(255, 2));
    val[0] = 8'($urandom);
    idx[1] = REG_TRUE;
    val[1] = t;
    idx[2] = REG_FALSE;
    val[2] = f;
    wait_drained(20);
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= val[k];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_true  = t;
    cur_false = f;
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return cur_true;
      3: return cur_false;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_flag();
    case ($urandom_range(3))
      0, 1: return cur_true;
      2: return cur_false;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [3:0] pick_binop();
    case ($urandom_range(9))
      0: return CMD_ADD;
      1: return CMD_SUB;
      2: return CMD_MUL;
      3: return CMD_DIV;
      4: return CMD_MOD;
      5: return CMD_EQ;
      6: return CMD_LT;
      7: return CMD_GT;
      8: return CMD_AND;
      default: return CMD_OR;
    endcase
  endfunction

  task automatic run_arith();
    send_cmd(CMD_PUSH, pick_byte());
    send_cmd(CMD_PUSH, pick_byte());
    send_cmd(pick_binop(), 8'($urandom));
    send_cmd($urandom_range(1) ? CMD_PRINT : CMD_PUTCH, 8'($urandom));
  endtask

  // leave a full stack over a zero, hit both overflows, then walk it out
  task automatic run_fill_walk();
    repeat (predicted_depth + 2) send_cmd(CMD_PRINT, 8'($urandom));
    send_cmd(CMD_PUSH, 8'd0);
    repeat (STACK_DEPTH - 1) send_cmd(CMD_PUSH, 8'($urandom_range(255, 1)));
    send_cmd(CMD_PUSH, 8'($urandom));
    send_cmd(CMD_DUP, 8'($urandom));
    send_cmd(CMD_PUTSTR, 8'($urandom));
  endtask

  task automatic run_sequence();
    int r;
    r = $urandom_range(99);
    if (predicted_depth > 26 && r < 40) begin
      repeat ($urandom_range(10, 3))
        send_cmd($urandom_range(1) ? CMD_PRINT : CMD_PUTCH, 8'($urandom));
    end else if (r < 30) begin
      run_arith();
    end else if (r < 50) begin
      send_cmd(CMD_PUSH, 8'd0);
      repeat ($urandom_range(6)) send_cmd(CMD_PUSH, 8'($urandom_range(255, 1)));
      send_cmd(CMD_PUTSTR, 8'($urandom));
    end else if (r < 65) begin
      send_cmd(CMD_PUSH, pick_flag());
      if ($urandom_range(1)) begin
        send_cmd(CMD_NOT, 8'($urandom));
      end else begin
        send_cmd(CMD_PUSH, pick_flag());
        send_cmd($urandom_range(1) ? CMD_AND : CMD_OR, 8'($urandom));
      end
      send_cmd(CMD_PRINT, 8'($urandom));
    end else if (r < 75) begin
      send_cmd(CMD_PUSH, pick_byte());
      send_cmd(CMD_DUP, 8'($urandom));
      send_cmd($urandom_range(1) ? CMD_EQ : CMD_PRINT, 8'($urandom));
    end else begin
      send_cmd(4'($urandom_range(15)), 8'($urandom));
    end
  endtask

  initial begin
    int p;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // empty stack: underflow on output, on the string walk with no zero, on a binary op
    send_cmd(CMD_PRINT, 8'd0);
    send_cmd(CMD_PUTSTR, 8'd0);
    send_cmd(CMD_ADD, 8'd255);
    // zero on top gives a bare done; then a two-character string
    send_cmd(CMD_PUSH, 8'd0);
    send_cmd(CMD_PUTSTR, 8'd0);
    send_cmd(CMD_PUSH, 8'd255);
    send_cmd(CMD_PUSH, 8'h48);
    send_cmd(CMD_PUTSTR, 8'd0);
    // wrapping add, zero divisor for div and mod
    send_cmd(CMD_PUSH, 8'd200);
    send_cmd(CMD_PUSH, 8'd100);
    send_cmd(CMD_ADD, 8'd0);
    send_cmd(CMD_PUSH, 8'd0);
    send_cmd(CMD_DIV, 8'd0);
    send_cmd(CMD_MOD, 8'd0);
    send_cmd(CMD_MUL, 8'd0);
    send_cmd(CMD_PUSH, 8'd1);
    send_cmd(CMD_SUB, 8'd0);
    send_cmd(CMD_DUP, 8'd0);
    send_cmd(CMD_EQ, 8'd0);
    send_cmd(CMD_NOT, 8'd0);
    send_cmd(CMD_PUSH, 8'd1);
    send_cmd(CMD_AND, 8'd0);
    send_cmd(CMD_OR, 8'd0);
    send_cmd(CMD_PUSH, 8'd9);
    send_cmd(CMD_LT, 8'd0);
    send_cmd(CMD_GT, 8'd0);
    send_cmd(CMD_PUTCH, 8'd0);
    send_cmd(CMD_PRINT, 8'd0);

    for (p = 0; p < 5; p++) begin
      case (p)
        0: begin
          program_flags(8'd255, 8'd0);
          idle_pct = 0;
          stall_pct <= 0;
        end
        1: begin
          program_flags(8'd0, 8'd255);
          idle_pct = 78;
          stall_pct <= 0;
        end
        2: begin
          program_flags(8'd7, 8'd7);
          idle_pct = 0;
          stall_pct <= 78;
        end
        3: begin
          program_flags(8'($urandom), 8'($urandom));
          idle_pct = 8;
          stall_pct <= 8;
        end
        default: begin
          program_flags(8'd1, 8'd0);
          idle_pct = 0;
          stall_pct <= 0;
          // receiver holds off while commands keep coming, so the queue backs up
          hold_requests <= hold_requests + 1;
          repeat (6) run_arith();
          wait_drained(20);
          run_fill_walk();
        end
      endcase
      while (sent_count < OPENING + (p + 1) * PHASE_ITEMS) run_sequence();
    end

    stall_pct <= 0;
    wait_drained(120);
    $display("Sent %0d stack commands under five true/false settings",
             sent_count);
    $display("and four idle/stall mixes, with a long output hold-off and a");
    $display("full-stack string walk; %0d results, %0d errors.",
             result_count, error_count);
    if (fail_count == 0 && awaited_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
